/* src/system_tick_timer_assert.svh */
// Assertion macros used by the system tick timer top level.
`ifndef SYSTEM_TICK_TIMER_ASSERT_SVH
`define SYSTEM_TICK_TIMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STT_ASSERT_NOW(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define STT_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* src/stt_pkg.sv */
// Types and constants of the system tick timer.
`default_nettype none
package stt_pkg;

    localparam logic [15:0] INTERVAL_RESET = 16'd128;
    localparam logic [3:0]  SHIFT_RESET    = 4'd7;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic CFG_INTERVAL      = 1'b0;
    localparam logic CFG_SECONDS_SHIFT = 1'b1;

    typedef struct packed {
        logic [15:0] expiry_time;
        logic        expiry_pending;
        logic [15:0] set_timer;
        logic [15:0] set_ticks;
        logic [1:0]  operation;
    } item_t;

    typedef struct packed {
        logic [15:0] interval;
        logic [3:0]  seconds_shift;
    } cfg_t;

    // Packed so that tick_count lands in the lowest bits
    typedef struct packed {
        logic        poll_request;
        logic        tick_fired;
        logic [15:0] timer_value;
        logic [15:0] fine_time;
        logic [31:0] seconds_count;
        logic [15:0] tick_count;
    } result_t;

endpackage
`default_nettype wire

/* src/stt_cfg_regs.sv */
// Configuration registers of the system tick timer.
`default_nettype none
module stt_cfg_regs
    import stt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_data,
    output cfg_t             cfg
);

    logic [15:0] interval_reg, interval_next;
    logic [3:0]  shift_reg, shift_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        interval_next = interval_reg;
        shift_next    = shift_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                CFG_INTERVAL:      interval_next = cfg_data;
                CFG_SECONDS_SHIFT: shift_next    = cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
            shift_reg    <= SHIFT_RESET;
        end else begin
            interval_reg <= interval_next;
            shift_reg    <= shift_next;
        end
    end

    assign cfg.interval      = interval_reg;
    assign cfg.seconds_shift = shift_reg;

endmodule
`default_nettype wire

/* src/stt_in_stage.sv */
// Input register stage of the system tick timer.
`default_nettype none
module stt_in_stage
    import stt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,
    input  wire logic [55:0] s_tdata,
    input  wire logic        fire,
    output logic             item_valid,
    output item_t            item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  take;

    // Refill in the same cycle the held beat moves on
    assign s_tready = !valid_reg || fire;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take) begin
            valid_next               = 1'b1;
            item_next.operation      = s_tuser;
            item_next.set_ticks      = s_tdata[15:0];
            item_next.set_timer      = s_tdata[31:16];
            item_next.expiry_pending = s_tdata[32];
            item_next.expiry_time    = s_tdata[48:33];
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

/* src/stt_clock_core.sv */
// Timer, compare and tick/seconds state with the per-beat update logic.
`default_nettype none
module stt_clock_core
    import stt_pkg::*;
#(
    parameter int TICK_WIDTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic fire,
    input  item_t     item,
    input  cfg_t      cfg,
    output result_t   result
);

    logic [15:0]           timer_reg, timer_next;
    logic [15:0]           compare_reg, compare_next;
    logic [TICK_WIDTH-1:0] ticks_reg, ticks_next;
    logic [31:0]           seconds_reg, seconds_next;
    logic [15:0]           capture_reg, capture_next;

    logic [15:0]           timer_inc;
    logic [TICK_WIDTH-1:0] ticks_inc;
    logic [TICK_WIDTH-1:0] smask;
    logic [TICK_WIDTH-1:0] expiry_diff;
    logic [TICK_WIDTH+15:0] set_ticks_ext;
    logic [TICK_WIDTH+15:0] expiry_ext;
    logic [TICK_WIDTH+15:0] ticks_out_ext;
    logic                  fired;
    logic                  poll;

    assign timer_inc     = timer_reg + 16'd1;
    assign ticks_inc     = ticks_reg + {{(TICK_WIDTH-1){1'b0}}, 1'b1};
    assign set_ticks_ext = {{TICK_WIDTH{1'b0}}, item.set_ticks};
    assign expiry_ext    = {{TICK_WIDTH{1'b0}}, item.expiry_time};
    // expiry - ticks_inc - 1 modulo the tick range; the top bit set means due or past
    assign expiry_diff   = expiry_ext[TICK_WIDTH-1:0] + ~ticks_inc;

    always_comb begin
        for (int i = 0; i < TICK_WIDTH; i++) begin
            smask[i] = (i < int'(cfg.seconds_shift));
        end
    end

    always_comb begin
        timer_next   = timer_reg;
        compare_next = compare_reg;
        ticks_next   = ticks_reg;
        seconds_next = seconds_reg;
        capture_next = capture_reg;
        fired        = 1'b0;
        poll         = 1'b0;
        case (item.operation)
            OP_TICK: begin
                timer_next = timer_inc;
                if (timer_inc == compare_reg) begin
                    compare_next = compare_reg + cfg.interval;
                    ticks_next   = ticks_inc;
                    if ((ticks_inc & smask) == '0) begin
                        seconds_next = seconds_reg + 32'd1;
                    end
                    capture_next = timer_inc;
                    fired        = 1'b1;
                    poll         = item.expiry_pending && expiry_diff[TICK_WIDTH-1];
                end
            end
            OP_SET: begin
                timer_next   = item.set_timer;
                compare_next = item.set_timer + cfg.interval;
                ticks_next   = set_ticks_ext[TICK_WIDTH-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg   <= '0;
            compare_reg <= INTERVAL_RESET;
            ticks_reg   <= '0;
            seconds_reg <= '0;
            capture_reg <= '0;
        end else if (fire) begin
            timer_reg   <= timer_next;
            compare_reg <= compare_next;
            ticks_reg   <= ticks_next;
            seconds_reg <= seconds_next;
            capture_reg <= capture_next;
        end
    end

    assign ticks_out_ext = {16'd0, ticks_next};

    assign result.tick_count    = ticks_out_ext[15:0];
    assign result.seconds_count = seconds_next;
    assign result.fine_time     = timer_next - capture_next;
    assign result.timer_value   = timer_next;
    assign result.tick_fired    = fired;
    assign result.poll_request  = poll;

endmodule
`default_nettype wire

/* src/stt_out_stage.sv */
// Result register stage of the system tick timer.
`default_nettype none
module stt_out_stage
    import stt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  result_t          result,
    output logic             out_free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = result;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, data_reg};

endmodule
`default_nettype wire

/* src/system_tick_timer.sv */
// Top level of the compare-match system tick timer.
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid/s_tready   | s_tuser operation, s_tdata operands
//  m_      | out | m_tvalid/m_tready   | m_tdata clock readout
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_addr register index, cfg_data value
//
// One beat per cycle sustained while the m_ side accepts; an input beat passes the input
// register, then the timer update logic into the result register.
// aresetn is synchronous: timer, ticks, seconds and capture clear, compare loads 128,
// interval 128, seconds shift 7. A stalled m_ side holds the result and the
// input register; one further input beat is taken while the result waits.
// cfg_ready is always high.
`default_nettype none
`include "system_tick_timer_assert.svh"
module system_tick_timer
    import stt_pkg::*;
#(
    parameter int TICK_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] operation
    input  wire logic [1:0]  s_tuser,
    // [15:0] set_ticks, [31:16] set_timer, [32] expiry_pending, [48:33] expiry_time
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] tick_count, [47:16] seconds_count, [63:48] fine_time,
    // [79:64] timer_value, [80] tick_fired, [81] poll_request
    output logic [87:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_data
);

    cfg_t    cfg;
    item_t   item;
    result_t result;
    logic    item_valid;
    logic    out_free;
    logic    fire;

    assign fire = item_valid && out_free;

    stt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stt_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    stt_clock_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    stt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Poll is only evaluated on a compare match
    `STT_ASSERT_NOW(a_poll_needs_fire, aclk, aresetn, m_tvalid && m_tdata[81], m_tdata[80], "poll_request without tick_fired")
    // A match captures the timer, so fine time restarts at zero
    `STT_ASSERT_NOW(a_fire_fine_zero, aclk, aresetn, m_tvalid && m_tdata[80], m_tdata[63:48] == 16'd0, "fine_time not zero on tick")
    // Input side only stalls while the input register holds a beat
    `STT_ASSERT_NOW(a_stall_only_full, aclk, aresetn, !s_tready, item_valid, "s_tready low with empty input register")
    // A beat moved into the result register is presented next cycle
    `STT_ASSERT_NEXT(a_fire_shows, aclk, aresetn, fire, m_tvalid, "result lost after transfer")

endmodule
`default_nettype wire
